@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion helpers shared by the formatter modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CHK_IMPLY(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");

// next-cycle implication, checked out of reset
`define CHK_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

@@ hdl/i2a_pkg.sv @@
// ---------------------------------------------------------------------------
// i2a_pkg
// shared types and constants of the integer to ascii formatter
// ---------------------------------------------------------------------------
package i2a_pkg;

    localparam int VAL_W = 32;
    localparam int OP_W  = 2;
    localparam int FW_W  = 4;
    localparam int CNT_W = 4;
    localparam int CH_W  = 7;

    localparam logic [OP_W-1:0] OP_DEC      = 2'd0;
    localparam logic [OP_W-1:0] OP_HEX_LOW  = 2'd1;
    localparam logic [OP_W-1:0] OP_HEX_UP   = 2'd2;

    localparam logic [FW_W-1:0]  WIDTH_MAX = 4'd9;
    localparam logic [CNT_W-1:0] OUT_MAX   = 4'd9;

    localparam logic [CH_W-1:0] CH_ZERO    = 7'h30;
    localparam logic [CH_W-1:0] CH_MINUS   = 7'h2D;
    localparam logic [CH_W-1:0] CH_SPACE   = 7'h20;
    localparam logic [CH_W-1:0] CH_UPPER_A = 7'h41;
    localparam logic [CH_W-1:0] CH_LOWER_A = 7'h61;

    typedef struct packed {
        logic            upper;
        logic            minus;
        logic            zero_pad;
        logic [FW_W-1:0] width;
    } t_fmt;

endpackage

@@ hdl/i2a_dabble.sv @@
// ---------------------------------------------------------------------------
// i2a_dabble
// bit-serial binary to bcd converter, one input bit per cycle (shift-add-3)
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2a_dabble #(
    parameter int NDIG = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [i2a_pkg::VAL_W-1:0]  i_bin,
    output logic                       o_busy,
    output logic                       o_done,
    output logic                       o_ovf,
    output logic [4*NDIG-1:0]          o_bcd
);

    localparam int DW = 4 * NDIG;
    localparam int CW = $clog2(i2a_pkg::VAL_W);

    logic [i2a_pkg::VAL_W-1:0] r_bin;
    logic [DW-1:0]             r_bcd;
    logic [CW-1:0]             r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic                      r_ovf;
    logic [DW-1:0]             adj;

    // digits above the kept ones are simply shifted out the top
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            adj[4*d +: 4] = (r_bcd[4*d +: 4] > 4'd4) ? r_bcd[4*d +: 4] + 4'd3
                                                     : r_bcd[4*d +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_bin  <= i_bin;
                r_bcd  <= '0;
                r_ovf  <= 1'b0;
            end else if (r_busy) begin
                r_bcd <= {adj[DW-2:0], r_bin[i2a_pkg::VAL_W-1]};
                r_bin <= r_bin << 1;
                r_cnt <= r_cnt + CW'(1);
                // a one leaving the top means the value has more digits than kept
                if (adj[DW-1]) begin
                    r_ovf <= 1'b1;
                end
                if (r_cnt == CW'(i2a_pkg::VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_bcd  = r_bcd;

    `CHK_IMPLY(a_no_restart, i_clk, i_rst_n, i_start, !r_busy)

endmodule

@@ hdl/i2a_emit.sv @@
// ---------------------------------------------------------------------------
// i2a_emit
// digit shift register that trims leading zeros, sizes the padded field
// and sends it one character per transaction
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2a_emit #(
    parameter int NDIG = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [4*NDIG-1:0]           i_digits,
    input  logic                        i_full,
    input  i2a_pkg::t_fmt               i_fmt,
    output logic                        o_busy,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [i2a_pkg::CH_W-1:0]    o_character,
    output logic                        o_last
);

    localparam int DW = 4 * NDIG;
    localparam int TW = (NDIG > 1) ? $clog2(NDIG) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_SIZE,
        S_ALIGN,
        S_SEND
    } t_state;

    t_state                       r_state;
    logic [DW-1:0]                r_dig;
    logic                         r_full;
    i2a_pkg::t_fmt                r_fmt;
    logic [TW-1:0]                r_top;
    logic [i2a_pkg::CNT_W-1:0]    r_ndig;
    logic [i2a_pkg::CNT_W-1:0]    r_len;
    logic [i2a_pkg::CNT_W-1:0]    r_pos;
    logic                         r_valid;
    logic [i2a_pkg::CH_W-1:0]     r_char;
    logic                         r_last;

    logic [3:0]                   nib;
    logic [i2a_pkg::CH_W-1:0]     dig_ch;
    logic [i2a_pkg::CH_W-1:0]     ch;
    logic [i2a_pkg::CNT_W-1:0]    wd;
    logic [i2a_pkg::CNT_W-1:0]    tgt;
    logic [i2a_pkg::CNT_W-1:0]    dm;
    logic [i2a_pkg::CNT_W-1:0]    len;
    logic                         minus_here;
    logic                         out_free;

    assign nib      = r_dig[DW-1 -: 4];
    assign out_free = !r_valid || i_ready;

    always_comb begin
        if (nib > 4'd9) begin
            dig_ch = (r_fmt.upper ? i2a_pkg::CH_UPPER_A : i2a_pkg::CH_LOWER_A)
                     + {3'b000, nib - 4'd10};
        end else begin
            dig_ch = i2a_pkg::CH_ZERO + {3'b000, nib};
        end
    end

    // field length: zero padding fills after the minus, space padding before it
    always_comb begin
        wd  = r_fmt.width;
        tgt = (r_fmt.minus && wd != '0) ? wd - 4'd1 : wd;
        dm  = r_ndig + {3'b000, r_fmt.minus};
        if (r_fmt.zero_pad) begin
            len = ((r_ndig > tgt) ? r_ndig : tgt) + {3'b000, r_fmt.minus};
        end else begin
            len = (dm > wd) ? dm : wd;
        end
    end

    always_comb begin
        minus_here = r_fmt.minus && (r_fmt.zero_pad ? (r_pos == r_len - 4'd1)
                                                    : (r_pos == r_ndig));
        if (r_pos < r_ndig) begin
            ch = dig_ch;
        end else if (minus_here) begin
            ch = i2a_pkg::CH_MINUS;
        end else begin
            ch = r_fmt.zero_pad ? i2a_pkg::CH_ZERO : i2a_pkg::CH_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            // while sending, the send arm below decides the output register
            if (r_state != S_SEND && r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_load) begin
                        r_dig   <= i_digits;
                        r_full  <= i_full;
                        r_fmt   <= i_fmt;
                        r_top   <= TW'(NDIG - 1);
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    // leading zeros are real digits when higher digits were dropped
                    if (!r_full && r_top != '0 && nib == 4'd0) begin
                        r_dig <= r_dig << 4;
                        r_top <= r_top - TW'(1);
                    end else begin
                        r_ndig  <= i2a_pkg::CNT_W'(r_top) + 4'd1;
                        r_state <= S_SIZE;
                    end
                end
                S_SIZE: begin
                    r_len   <= len;
                    r_pos   <= ((len > i2a_pkg::OUT_MAX) ? i2a_pkg::OUT_MAX : len) - 4'd1;
                    r_state <= S_ALIGN;
                end
                S_ALIGN: begin
                    // drop digits that fall outside the emitted window
                    if (i2a_pkg::CNT_W'(r_top) > r_pos) begin
                        r_dig <= r_dig << 4;
                        r_top <= r_top - TW'(1);
                    end else begin
                        r_state <= S_SEND;
                    end
                end
                S_SEND: begin
                    if (out_free) begin
                        r_valid <= 1'b1;
                        r_char  <= ch;
                        r_last  <= (r_pos == '0);
                        if (r_pos < r_ndig) begin
                            r_dig <= r_dig << 4;
                            r_top <= r_top - TW'(1);
                        end
                        if (r_pos == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pos <= r_pos - 4'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    `CHK_IMPLY(a_load_idle, i_clk, i_rst_n, i_load, r_state == S_IDLE)
    `CHK_IMPLY(a_pos_window, i_clk, i_rst_n, r_state == S_SEND, r_pos < i2a_pkg::OUT_MAX)

endmodule

@@ hdl/integer_to_ascii_formatter.sv @@
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter
// formats a 32-bit integer as signed decimal or hex ascii with padding
// ---------------------------------------------------------------------------
// One number is taken per input transaction and leaves as 1 to 9 characters,
// most significant first, with o_last on the final one. Numbers are handled
// one at a time: o_ready stays low after an acceptance until the digit shift
// register, which trims leading zero digits one per cycle, has put the last
// character into its output register. A decimal number first passes through
// the bit-serial binary to bcd converter, which consumes one value bit per
// cycle. Characters leave one per cycle when the sink is ready; the output
// register lets the last character wait while the next number is accepted.
`include "assert_macros.svh"

module integer_to_ascii_formatter #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [i2a_pkg::OP_W-1:0]     i_operation,
    input  logic [i2a_pkg::VAL_W-1:0]    i_value,
    input  logic                         i_zero_pad,
    input  logic [i2a_pkg::FW_W-1:0]     i_field_width,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [i2a_pkg::CH_W-1:0]     o_character,
    output logic                         o_last
);

    localparam int DW = 4 * MAX_DIGITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state                      r_state;
    i2a_pkg::t_fmt               r_fmt;

    logic                        accept;
    logic                        is_dec;
    i2a_pkg::t_fmt               port_fmt;
    logic [i2a_pkg::VAL_W-1:0]   mag;
    logic [DW+i2a_pkg::VAL_W-1:0] hex_ext;
    logic [DW-1:0]               hex_dig;
    logic                        hex_ovf;
    logic                        conv_busy;
    logic                        conv_done;
    logic                        conv_ovf;
    logic [DW-1:0]               bcd;
    logic                        emit_load;
    logic [DW-1:0]               emit_dig;
    logic                        emit_full;
    i2a_pkg::t_fmt               emit_fmt;
    logic                        emit_busy;

    assign accept = i_valid && o_ready;
    assign is_dec = (i_operation == i2a_pkg::OP_DEC);

    always_comb begin
        port_fmt.upper    = (i_operation != i2a_pkg::OP_HEX_LOW);
        port_fmt.minus    = is_dec && i_value[i2a_pkg::VAL_W-1];
        port_fmt.zero_pad = i_zero_pad;
        port_fmt.width    = (i_field_width > i2a_pkg::WIDTH_MAX) ? i2a_pkg::WIDTH_MAX
                                                                 : i_field_width;
    end

    // the most negative value maps onto itself, read as unsigned
    assign mag     = port_fmt.minus ? (~i_value) + 32'd1 : i_value;
    assign hex_ext = {{DW{1'b0}}, i_value};
    assign hex_dig = hex_ext[DW-1:0];
    assign hex_ovf = (hex_ext[DW+i2a_pkg::VAL_W-1:DW] != '0);

    assign emit_load = (r_state == S_IDLE) ? (accept && !is_dec) : conv_done;
    assign emit_dig  = (r_state == S_IDLE) ? hex_dig : bcd;
    assign emit_full = (r_state == S_IDLE) ? hex_ovf : conv_ovf;
    assign emit_fmt  = (r_state == S_IDLE) ? port_fmt : r_fmt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_fmt   <= port_fmt;
                        r_state <= is_dec ? S_CONV : S_EMIT;
                    end
                end
                S_CONV: begin
                    if (conv_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!emit_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);

    i2a_dabble #(
        .NDIG (MAX_DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && is_dec),
        .i_bin   (mag),
        .o_busy  (conv_busy),
        .o_done  (conv_done),
        .o_ovf   (conv_ovf),
        .o_bcd   (bcd)
    );

    i2a_emit #(
        .NDIG (MAX_DIGITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (emit_load),
        .i_digits    (emit_dig),
        .i_full      (emit_full),
        .i_fmt       (emit_fmt),
        .o_busy      (emit_busy),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

    `CHK_IMPLY(a_ready_units_idle, i_clk, i_rst_n, o_ready, !emit_busy && !conv_busy)

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// checks integer_to_ascii_formatter character by character against a
// behavioral renderer, under random idling, stalls and a long sink hold-off
// ---------------------------------------------------------------------------

typedef struct {
    logic [i2a_pkg::CH_W-1:0] ch;
    logic                     last;
} t_char;

class ascii_scoreboard;
    localparam int DIGITS_KEPT = 8;

    t_char       pending_chars[$];
    int unsigned errors;
    int unsigned chars_checked;
    int unsigned numbers_by_op[4];

    // renders one number into the queue of expected characters
    function void note_number(input logic [i2a_pkg::OP_W-1:0] op,
                              input logic [i2a_pkg::VAL_W-1:0] value,
                              input logic zero_pad,
                              input logic [i2a_pkg::FW_W-1:0] field_width);
        logic [i2a_pkg::CH_W-1:0] text[$];
        logic [i2a_pkg::VAL_W-1:0] mag;
        logic [i2a_pkg::CH_W-1:0] alpha;
        logic [3:0] nib;
        logic minus;
        int width;
        int target;
        t_char c;
        width = (field_width > i2a_pkg::WIDTH_MAX) ? int'(i2a_pkg::WIDTH_MAX)
                                                   : int'(field_width);
        mag = value;
        minus = 1'b0;
        numbers_by_op[op]++;
        if (op == i2a_pkg::OP_DEC) begin
            if (mag[i2a_pkg::VAL_W-1]) begin
                mag = ~mag + 1'b1;
                minus = 1'b1;
            end
            if (mag == 0)
                text.push_front(i2a_pkg::CH_ZERO);
            while (mag != 0 && text.size() < DIGITS_KEPT) begin
                text.push_front(i2a_pkg::CH_ZERO + i2a_pkg::CH_W'(mag % 10));
                mag = mag / 10;
            end
            if (zero_pad) begin
                target = minus ? width - 1 : width;
                while (text.size() < target)
                    text.push_front(i2a_pkg::CH_ZERO);
                if (minus)
                    text.push_front(i2a_pkg::CH_MINUS);
            end else begin
                if (minus)
                    text.push_front(i2a_pkg::CH_MINUS);
                while (text.size() < width)
                    text.push_front(i2a_pkg::CH_SPACE);
            end
        end else begin
            // reserved code renders as upper-case hex
            alpha = (op == i2a_pkg::OP_HEX_LOW) ? i2a_pkg::CH_LOWER_A : i2a_pkg::CH_UPPER_A;
            if (mag == 0)
                text.push_front(i2a_pkg::CH_ZERO);
            while (mag != 0 && text.size() < DIGITS_KEPT) begin
                nib = mag[3:0];
                if (nib > 9)
                    text.push_front(alpha + i2a_pkg::CH_W'(nib - 10));
                else
                    text.push_front(i2a_pkg::CH_ZERO + i2a_pkg::CH_W'(nib));
                mag = mag >> 4;
            end
            while (text.size() < width)
                text.push_front(zero_pad ? i2a_pkg::CH_ZERO : i2a_pkg::CH_SPACE);
        end
        // keep only the trailing characters when the text runs long
        while (text.size() > i2a_pkg::OUT_MAX)
            void'(text.pop_front());
        foreach (text[k]) begin
            c.ch = text[k];
            c.last = (k == text.size() - 1);
            pending_chars.push_back(c);
        end
    endfunction

    function void check_char(input logic [i2a_pkg::CH_W-1:0] ch, input logic last);
        t_char want;
        if (pending_chars.size() == 0) begin
            $error("unexpected character: actual %h last %b", ch, last);
            errors++;
        end else begin
            want = pending_chars.pop_front();
            chars_checked++;
            if (ch !== want.ch) begin
                $error("character mismatch: expected %h actual %h", want.ch, ch);
                errors++;
            end
            if (last !== want.last) begin
                $error("last mismatch: expected %b actual %b", want.last, last);
                errors++;
            end
        end
    endfunction
endclass

module tb;
    localparam int DIGITS_KEPT = 8;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 120;
    localparam logic [i2a_pkg::OP_W-1:0] OP_RSVD = 2'd3;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [i2a_pkg::OP_W-1:0]     i_operation;
    logic [i2a_pkg::VAL_W-1:0]    i_value;
    logic                         i_zero_pad;
    logic [i2a_pkg::FW_W-1:0]     i_field_width;
    logic                         o_valid;
    logic                         i_ready;
    logic [i2a_pkg::CH_W-1:0]     o_character;
    logic                         o_last;

    int unsigned snd_idle_pct;
    int unsigned rcv_stall_pct;
    logic        hold_request;

    ascii_scoreboard sb = new();

    integer_to_ascii_formatter #(
        .MAX_DIGITS(DIGITS_KEPT)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_zero_pad    (i_zero_pad),
        .i_field_width (i_field_width),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_character   (o_character),
        .o_last        (o_last)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_number(input logic [i2a_pkg::OP_W-1:0] op,
                               input logic [i2a_pkg::VAL_W-1:0] value,
                               input logic zero_pad,
                               input logic [i2a_pkg::FW_W-1:0] field_width);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_value       <= value;
        i_zero_pad    <= zero_pad;
        i_field_width <= field_width;
        do @(posedge i_clk); while (!o_ready);
        sb.note_number(op, value, zero_pad, field_width);
        @(negedge i_clk);
    endtask

    task automatic send_random_number();
        logic [i2a_pkg::OP_W-1:0]  op;
        logic [i2a_pkg::VAL_W-1:0] value;
        logic [i2a_pkg::FW_W-1:0]  fw;
        op = ($urandom_range(0, 9) == 0) ? OP_RSVD : i2a_pkg::OP_W'($urandom_range(0, 2));
        case ($urandom_range(0, 5))
            0:       value = $urandom_range(0, 999);
            1:       value = -$urandom_range(1, 999);
            2:       value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3:       value = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            default: value = $urandom();
        endcase
        fw = ($urandom_range(0, 7) == 0) ? i2a_pkg::FW_W'($urandom_range(10, 15))
                                         : i2a_pkg::FW_W'($urandom_range(0, 9));
        send_number(op, value, 1'($urandom_range(0, 1)), fw);
    endtask

    // sink side: random stalls, plus one long hold-off on request
    initial begin : sink
        int held;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (held = 0; held < LONG_HOLD; held++) begin
                    i_ready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            i_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_char(o_character, o_last);
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_operation   = i2a_pkg::OP_DEC;
        i_value       = '0;
        i_zero_pad    = 1'b0;
        i_field_width = '0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_request  = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners
        send_number(i2a_pkg::OP_DEC,     32'd0,          1'b0, 4'd0);
        send_number(i2a_pkg::OP_DEC,     32'h7FFF_FFFF,  1'b0, 4'd0);
        send_number(i2a_pkg::OP_DEC,     32'h8000_0000,  1'b1, 4'd9);
        send_number(i2a_pkg::OP_DEC,     32'h8000_0000,  1'b0, 4'd0);
        send_number(i2a_pkg::OP_DEC,     -32'sd5,        1'b1, 4'd0);
        send_number(i2a_pkg::OP_DEC,     -32'sd5,        1'b1, 4'd9);
        send_number(i2a_pkg::OP_DEC,     -32'sd5,        1'b0, 4'd9);
        send_number(i2a_pkg::OP_DEC,     32'd12345,      1'b1, 4'd9);
        send_number(i2a_pkg::OP_DEC,     32'hFFFF_FFFF,  1'b0, 4'd15);
        send_number(i2a_pkg::OP_DEC,     32'd100000000,  1'b0, 4'd0);
        send_number(i2a_pkg::OP_DEC,     32'd7,          1'b0, 4'd1);
        send_number(i2a_pkg::OP_HEX_LOW, 32'hDEAD_BEEF,  1'b0, 4'd0);
        send_number(i2a_pkg::OP_HEX_UP,  32'hDEAD_BEEF,  1'b1, 4'd9);
        send_number(i2a_pkg::OP_HEX_LOW, 32'd0,          1'b0, 4'd9);
        send_number(i2a_pkg::OP_HEX_UP,  32'h0000_ABCD,  1'b0, 4'd12);
        send_number(OP_RSVD,             32'h00C0_FFEE,  1'b1, 4'd10);
        send_number(i2a_pkg::OP_HEX_LOW, 32'hFFFF_FFFF,  1'b1, 4'd15);
        send_number(i2a_pkg::OP_HEX_UP,  32'h0123_4567,  1'b0, 4'd8);

        // random phases with different idling mixes
        repeat (PHASE_ITEMS) send_random_number();
        hold_request = 1'b1;
        repeat (30) send_random_number();
        snd_idle_pct = 51;
        repeat (PHASE_ITEMS) send_random_number();
        snd_idle_pct  = 0;
        rcv_stall_pct = 51;
        repeat (PHASE_ITEMS) send_random_number();
        snd_idle_pct  = 35;
        rcv_stall_pct = 35;
        repeat (PHASE_ITEMS) send_random_number();
        i_valid <= 1'b0;

        while (sb.pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("tb: %0d numbers (dec %0d, hex lower %0d, hex upper %0d, reserved %0d)",
                 sb.numbers_by_op[0] + sb.numbers_by_op[1] + sb.numbers_by_op[2]
                 + sb.numbers_by_op[3], sb.numbers_by_op[0], sb.numbers_by_op[1],
                 sb.numbers_by_op[2], sb.numbers_by_op[3]);
        $display("tb: %0d characters compared, %0d mismatches", sb.chars_checked, sb.errors);
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        #10ms;
        $display("tb: timeout");
        $display("tb: done, errors");
        $finish;
    end
endmodule
